### hdl/dmx512_three_slot_receiver_top_assert.svh
// Assertion macros used by the DMX512 three-slot receiver RTL.
`ifndef DMX512_THREE_SLOT_RECEIVER_TOP_ASSERT_SVH
`define DMX512_THREE_SLOT_RECEIVER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmx_rx assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmx_rx assertion failed");

`endif

### hdl/dmx_rx_pkg.sv
// Package with widths, codes and types of the DMX512 three-slot receiver.
package dmx_rx_pkg;

    localparam int unsigned SLOT_ADDRESS_W = 9;
    localparam int unsigned TIMEOUT_W      = 10;
    localparam int unsigned SLOT_COUNT_W   = 11;
    localparam int unsigned LEVEL_W        = 8;

    localparam int unsigned SLOT_COUNT_LIMIT_DEFAULT = 1023;

    localparam logic [SLOT_ADDRESS_W-1:0] SLOT_ADDRESS_RESET  = '0;
    localparam logic [TIMEOUT_W-1:0]      TIMEOUT_LIMIT_RESET = 10'd480;

    // Item kinds carried on tuser.
    localparam logic OPCODE_BYTE = 1'b0;
    localparam logic OPCODE_TICK = 1'b1;

    // Register map.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_SLOT_ADDRESS  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT_LIMIT = 3'd4;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 32;

    typedef struct packed {
        logic [SLOT_ADDRESS_W-1:0] slot_address;
        logic [TIMEOUT_W-1:0]      timeout_limit;
    } t_cfg;

    // Packed with red in the lowest bits, matching the output word layout.
    typedef struct packed {
        logic               packet_committed;
        logic               signal_present;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

### hdl/dmx512_three_slot_receiver_top.sv
// Top level of the DMX512 three-slot receiver: stream ports, pipeline and config port.
// A word waits in the input register until the result register is free, then its result
// is registered there. Throughput: one word per cycle while the result side accepts; the
// update logic between the two registers handles any word, byte or tick combinationally.
// Reset (synchronous, active low) empties both pipeline registers, clears the packet state,
// sets the idle count and timeout limit to 480 and the slot address to zero.
module dmx512_three_slot_receiver_top
    import dmx_rx_pkg::*;
#(
    // Saturation point of the slot counter; legal range 515 to 1023.
    parameter int unsigned SLOT_COUNT_LIMIT = SLOT_COUNT_LIMIT_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte, [8] frame_error, rest zero
    input  logic                   s_axis_tuser,  // [0] opcode (0 byte, 1 tick)

    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] red_level, [15:8] green_level,
                                                  // [23:16] blue_level, [24] signal_present,
                                                  // [25] packet_committed, rest zero

    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Two-entry pipeline: an input register holding the accepted word, and a result
    // register holding the finished result. The packet state is updated as a word moves
    // from the first to the second, so the order of state updates matches the order in
    // which words were accepted regardless of stalls on either side.
    logic                 r_in_valid;
    logic                 r_in_opcode;
    logic [LEVEL_W-1:0]   r_in_data_byte;
    logic                 r_in_frame_error;
    logic                 r_out_valid;
    t_result              r_out_result;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_fire;
    t_cfg                 w_cfg;
    t_result              w_result;

    // The result register can take a new result when it is empty or being drained.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    // A new word enters when the input register is empty or is moving on this cycle.
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_opcode      <= s_axis_tuser;
            r_in_data_byte   <= s_axis_tdata[LEVEL_W-1:0];
            r_in_frame_error <= s_axis_tdata[LEVEL_W];
        end
        if (w_advance) begin
            r_out_result <= w_result;
        end
    end

    dmx_rx_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // The core commits its state only when a word moves into the result register.
    dmx_rx_core #(
        .SLOT_COUNT_LIMIT (SLOT_COUNT_LIMIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_opcode      (r_in_opcode),
        .i_data_byte   (r_in_data_byte),
        .i_frame_error (r_in_frame_error),
        .i_cfg         (w_cfg),
        .o_result      (w_result)
    );

    assign pready        = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out_result};

endmodule

### hdl/dmx_rx_regs.sv
// Configuration register file of the DMX512 receiver behind an APB-style port.
module dmx_rx_regs
    import dmx_rx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    assign w_write = i_psel && i_penable && i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (i_paddr)
                ADDR_SLOT_ADDRESS:  n_cfg.slot_address  = i_pwdata[SLOT_ADDRESS_W-1:0];
                ADDR_TIMEOUT_LIMIT: n_cfg.timeout_limit = i_pwdata[TIMEOUT_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_address  <= SLOT_ADDRESS_RESET;
            r_cfg.timeout_limit <= TIMEOUT_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (i_paddr)
            ADDR_SLOT_ADDRESS:  o_prdata = APB_DATA_W'(r_cfg.slot_address);
            ADDR_TIMEOUT_LIMIT: o_prdata = APB_DATA_W'(r_cfg.timeout_limit);
            default:            o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/dmx_rx_core.sv
// Packet state of the DMX512 receiver and the per-word update logic.
module dmx_rx_core
    import dmx_rx_pkg::*;
#(
    parameter int unsigned SLOT_COUNT_LIMIT = SLOT_COUNT_LIMIT_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_opcode,
    input  logic [LEVEL_W-1:0] i_data_byte,
    input  logic               i_frame_error,
    input  t_cfg               i_cfg,
    output t_result            o_result
);

    `include "dmx512_three_slot_receiver_top_assert.svh"

    localparam logic [SLOT_COUNT_W-1:0] SLOT_MAX = SLOT_COUNT_W'(SLOT_COUNT_LIMIT);

    logic [SLOT_COUNT_W-1:0] r_slot_count, n_slot_count;
    logic [SLOT_COUNT_W-1:0] r_prev_size,  n_prev_size;
    logic                    r_packet_good, n_packet_good;
    logic [LEVEL_W-1:0]      r_cap_red,   n_cap_red;
    logic [LEVEL_W-1:0]      r_cap_green, n_cap_green;
    logic [LEVEL_W-1:0]      r_cap_blue,  n_cap_blue;
    logic [LEVEL_W-1:0]      r_held_red,   n_held_red;
    logic [LEVEL_W-1:0]      r_held_green, n_held_green;
    logic [LEVEL_W-1:0]      r_held_blue,  n_held_blue;
    logic [TIMEOUT_W-1:0]    r_idle_ticks, n_idle_ticks;
    logic                    w_committed;

    logic [SLOT_COUNT_W-1:0] w_slot_idx;
    logic [SLOT_COUNT_W-1:0] w_addr_red;
    logic                    w_is_break;
    logic                    w_good_at_break;

    assign w_slot_idx = r_slot_count - SLOT_COUNT_W'(1);
    assign w_addr_red = SLOT_COUNT_W'(i_cfg.slot_address);
    assign w_is_break = i_frame_error && (i_data_byte == '0);
    // A size change since the last break spoils the packet before the commit check.
    assign w_good_at_break = r_packet_good && (r_slot_count == r_prev_size);

    always_comb begin
        n_slot_count = r_slot_count;
        n_prev_size  = r_prev_size;
        n_packet_good = r_packet_good;
        n_cap_red    = r_cap_red;
        n_cap_green  = r_cap_green;
        n_cap_blue   = r_cap_blue;
        n_held_red   = r_held_red;
        n_held_green = r_held_green;
        n_held_blue  = r_held_blue;
        n_idle_ticks = r_idle_ticks;
        w_committed  = 1'b0;

        if (i_opcode == OPCODE_TICK) begin
            if (r_idle_ticks < i_cfg.timeout_limit) begin
                n_idle_ticks = r_idle_ticks + TIMEOUT_W'(1);
            end
        end else if (w_is_break) begin
            n_prev_size = r_slot_count;
            if (w_good_at_break) begin
                n_idle_ticks = '0;
                n_held_red   = r_cap_red;
                n_held_green = r_cap_green;
                n_held_blue  = r_cap_blue;
                w_committed  = 1'b1;
            end
            n_cap_red     = '0;
            n_cap_green   = '0;
            n_cap_blue    = '0;
            n_packet_good = 1'b1;
            n_slot_count  = '0;
        end else if (i_frame_error) begin
            n_packet_good = 1'b0;
        end else begin
            if (r_slot_count == '0) begin
                if (i_data_byte != '0) begin
                    n_packet_good = 1'b0;
                end
            end else if (w_slot_idx == w_addr_red) begin
                n_cap_red = i_data_byte;
            end else if (w_slot_idx == w_addr_red + SLOT_COUNT_W'(1)) begin
                n_cap_green = i_data_byte;
            end else if (w_slot_idx == w_addr_red + SLOT_COUNT_W'(2)) begin
                n_cap_blue = i_data_byte;
            end
            if (r_slot_count < SLOT_MAX) begin
                n_slot_count = r_slot_count + SLOT_COUNT_W'(1);
            end
        end

        // Timed out: pin the count at the limit and force the outputs off.
        if (n_idle_ticks >= i_cfg.timeout_limit) begin
            n_idle_ticks = i_cfg.timeout_limit;
            n_held_red   = '0;
            n_held_green = '0;
            n_held_blue  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count  <= '0;
            r_prev_size   <= '0;
            r_packet_good <= 1'b0;
            r_cap_red     <= '0;
            r_cap_green   <= '0;
            r_cap_blue    <= '0;
            r_held_red    <= '0;
            r_held_green  <= '0;
            r_held_blue   <= '0;
            r_idle_ticks  <= TIMEOUT_LIMIT_RESET;
        end else if (i_step) begin
            r_slot_count  <= n_slot_count;
            r_prev_size   <= n_prev_size;
            r_packet_good <= n_packet_good;
            r_cap_red     <= n_cap_red;
            r_cap_green   <= n_cap_green;
            r_cap_blue    <= n_cap_blue;
            r_held_red    <= n_held_red;
            r_held_green  <= n_held_green;
            r_held_blue   <= n_held_blue;
            r_idle_ticks  <= n_idle_ticks;
        end
    end

    assign o_result.red_level        = n_held_red;
    assign o_result.green_level      = n_held_green;
    assign o_result.blue_level       = n_held_blue;
    assign o_result.signal_present   = n_idle_ticks < i_cfg.timeout_limit;
    assign o_result.packet_committed = w_committed;

    `DMX_ASSERT_NEXT(a_idle_clamped, i_clk, i_rst_n, i_step,
        r_idle_ticks <= $past(i_cfg.timeout_limit))
    `DMX_ASSERT_NEXT(a_break_restarts, i_clk, i_rst_n,
        i_step && (i_opcode == OPCODE_BYTE) && w_is_break, r_slot_count == '0)
    `DMX_ASSERT_SAME(a_commit_only_at_break, i_clk, i_rst_n, w_committed,
        (i_opcode == OPCODE_BYTE) && w_is_break && r_packet_good)

endmodule

### tb/sv/dmx512_three_slot_receiver_top_test.sv
// Self-checking testbench for the DMX512 three-slot receiver top level.
module dmx512_three_slot_receiver_top_test;
    import dmx_rx_pkg::*;

    // Cycles without any accepted word, on either stream, before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Extra cycles waited after the last owed result, so that the pipeline is empty.
    localparam int DRAIN_CYCLES = 4;
    // Only the first mismatches are printed, the rest are only counted.
    localparam int MAX_REPORTS = 100;
    // Random words per ordinary phase.
    localparam int PHASE_WORDS = 150;

    // One input word: a received byte or a timeout tick.
    typedef struct packed {
        logic               opcode;
        logic [LEVEL_W-1:0] data_byte;
        logic               frame_error;
    } t_rx_word;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_SET_SLOT,
        ROW_SET_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_rx_word             word;
        logic [TIMEOUT_W-1:0] value;
        logic                 has_literal;
        t_result              literal;
    } t_directed_row;

    // Results that can be read straight off the behavior: everything dark, and
    // everything dark while a commit is reported (zero timeout limit).
    localparam t_result DARK        = '0;
    localparam t_result DARK_COMMIT = t_result'{1'b1, 1'b0, 8'h00, 8'h00, 8'h00};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    dmx512_three_slot_receiver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Receiver state as the testbench expects it to be. The configuration copy
    // follows every register write, the rest follows every accepted word.
    logic [SLOT_ADDRESS_W-1:0] cfg_slot_address;
    logic [TIMEOUT_W-1:0]      cfg_timeout_limit;
    logic [SLOT_COUNT_W-1:0]   rx_slot_count;
    logic [SLOT_COUNT_W-1:0]   rx_prev_size;
    logic                      rx_packet_good;
    logic [LEVEL_W-1:0]        cap_red, cap_green, cap_blue;
    logic [LEVEL_W-1:0]        held_red, held_green, held_blue;
    logic [TIMEOUT_W-1:0]      rx_idle_ticks;

    // Results still owed by the block, oldest first.
    t_result       expected_levels[$];
    t_rx_word      pending_words[$];
    t_directed_row directed_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int commits_seen   = 0;
    int dark_results   = 0;
    int reg_writes     = 0;
    int phases_run     = 0;

    // The clock runs high for five units and low for five.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side drops tready at random, as often as the current phase asks.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void report_mismatch(string name, int unsigned exp_val,
                                            int unsigned act_val);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
    endfunction

    // Applies one word to the expected receiver state and returns the result word
    // that the block should produce for it.
    function automatic t_result advance_receiver(t_rx_word w);
        t_result                 res;
        logic                    committed;
        logic [SLOT_COUNT_W-1:0] slot;
        logic [SLOT_COUNT_W-1:0] red_slot;
        committed = 1'b0;
        slot      = rx_slot_count - SLOT_COUNT_W'(1);
        red_slot  = SLOT_COUNT_W'(cfg_slot_address);
        if (w.opcode == OPCODE_TICK) begin
            if (rx_idle_ticks < cfg_timeout_limit)
                rx_idle_ticks = rx_idle_ticks + TIMEOUT_W'(1);
        end else if (w.frame_error) begin
            if (w.data_byte == '0) begin
                // A break closes the packet. A size change spoils it first.
                if (rx_slot_count != rx_prev_size) begin
                    rx_prev_size   = rx_slot_count;
                    rx_packet_good = 1'b0;
                end
                if (rx_packet_good) begin
                    rx_idle_ticks = '0;
                    held_red      = cap_red;
                    held_green    = cap_green;
                    held_blue     = cap_blue;
                    committed     = 1'b1;
                end
                cap_red        = '0;
                cap_green      = '0;
                cap_blue       = '0;
                rx_packet_good = 1'b1;
                rx_slot_count  = '0;
            end else begin
                // A damaged byte inside a packet is neither counted nor captured.
                rx_packet_good = 1'b0;
            end
        end else begin
            if (rx_slot_count == '0) begin
                if (w.data_byte != '0)
                    rx_packet_good = 1'b0;
            end else if (slot == red_slot) begin
                cap_red = w.data_byte;
            end else if (slot == red_slot + SLOT_COUNT_W'(1)) begin
                cap_green = w.data_byte;
            end else if (slot == red_slot + SLOT_COUNT_W'(2)) begin
                cap_blue = w.data_byte;
            end
            if (rx_slot_count < SLOT_COUNT_LIMIT_DEFAULT)
                rx_slot_count = rx_slot_count + SLOT_COUNT_W'(1);
        end
        // Timed out: the count pins to the limit and the light goes dark.
        if (rx_idle_ticks >= cfg_timeout_limit) begin
            rx_idle_ticks = cfg_timeout_limit;
            held_red      = '0;
            held_green    = '0;
            held_blue     = '0;
        end
        res.red_level        = held_red;
        res.green_level      = held_green;
        res.blue_level       = held_blue;
        res.signal_present   = (rx_idle_ticks < cfg_timeout_limit);
        res.packet_committed = committed;
        return res;
    endfunction

    // Result checking and the watchdog. Everything is sampled at the rising edge,
    // while the testbench only drives at the falling edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[RESULT_W-1:0];
                results_seen++;
                if (got.packet_committed)
                    commits_seen++;
                if (!got.signal_present)
                    dark_results++;
                if (expected_levels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result word 0x%h arrived with no expectation waiting",
                               m_axis_tdata);
                end else begin
                    want = expected_levels.pop_front();
                    if (got.red_level != want.red_level)
                        report_mismatch("red_level", 32'(want.red_level),
                                        32'(got.red_level));
                    if (got.green_level != want.green_level)
                        report_mismatch("green_level", 32'(want.green_level),
                                        32'(got.green_level));
                    if (got.blue_level != want.blue_level)
                        report_mismatch("blue_level", 32'(want.blue_level),
                                        32'(got.blue_level));
                    if (got.signal_present != want.signal_present)
                        report_mismatch("signal_present", 32'(want.signal_present),
                                        32'(got.signal_present));
                    if (got.packet_committed != want.packet_committed)
                        report_mismatch("packet_committed", 32'(want.packet_committed),
                                        32'(got.packet_committed));
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d results owed",
                         WATCHDOG_LIMIT, expected_levels.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offers one word on the input stream, after a random number of idle cycles.
    // Entered and left at a falling edge; tvalid stays high when words follow
    // back to back.
    task automatic send_word(input t_rx_word w, input bit use_literal,
                             input t_result literal);
        logic [IN_TDATA_W-1:0] packed_word;
        t_result               predicted;
        packed_word      = '0;
        packed_word[7:0] = w.data_byte;
        packed_word[8]   = w.frame_error;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= packed_word;
        s_axis_tuser  <= w.opcode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = advance_receiver(w);
        expected_levels.push_back(use_literal ? literal : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Waits until every owed result has come back and the pipeline is empty.
    task automatic wait_drained();
        while (expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register through the config port, then reads it back.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_SLOT_ADDRESS)
            cfg_slot_address = value[SLOT_ADDRESS_W-1:0];
        else if (addr == ADDR_TIMEOUT_LIMIT)
            cfg_timeout_limit = value[TIMEOUT_W-1:0];
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        want = (addr == ADDR_SLOT_ADDRESS) ? APB_DATA_W'(cfg_slot_address)
                                           : APB_DATA_W'(cfg_timeout_limit);
        if (prdata != want)
            report_mismatch(addr == ADDR_SLOT_ADDRESS ? "prdata slot_address"
                                                      : "prdata timeout_limit",
                            want, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic op, input logic [7:0] data,
                           input logic ferr, input int value, input bit has_lit,
                           input t_result lit);
        t_directed_row row;
        row.kind        = kind;
        row.word        = t_rx_word'{op, data, ferr};
        row.value       = value[TIMEOUT_W-1:0];
        row.has_literal = has_lit;
        row.literal     = lit;
        directed_rows.push_back(row);
    endtask

    function automatic void push_word(input logic op, input logic [7:0] data,
                                      input logic ferr);
        pending_words.push_back(t_rx_word'{op, data, ferr});
    endfunction

    // Queues a break, a start code and the data slots of one packet. With noise on,
    // a few start codes are nonzero and damaged bytes or ticks land mid-packet.
    function automatic void queue_packet(input int data_len, input bit noisy);
        int r;
        push_word(OPCODE_BYTE, 8'h00, 1'b1);
        if (noisy && $urandom_range(99) < 8)
            push_word(OPCODE_BYTE, 8'($urandom_range(255, 1)), 1'b0);
        else
            push_word(OPCODE_BYTE, 8'h00, 1'b0);
        for (int i = 0; i < data_len; i++) begin
            if (noisy) begin
                r = $urandom_range(99);
                if (r < 2)
                    push_word(OPCODE_BYTE, 8'($urandom_range(255, 1)), 1'b1);
                else if (r < 5)
                    push_word(OPCODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            push_word(OPCODE_BYTE, 8'($urandom_range(255)), 1'b0);
        end
    endfunction

    // One random phase: drain, set both registers, then stream packets. Outside the
    // long-packet phase, most of the stream is well-formed packets of often repeated
    // size, so that commits happen; the rest is ticks, noise bursts and broken packets.
    task automatic run_phase(input int addr, input int limit, input int idle_pct,
                             input int stall_pct, input int budget,
                             input bit long_packets, input bit pause_midway);
        int data_len;
        int last_len;
        int n;
        int r;
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_register(ADDR_SLOT_ADDRESS, APB_DATA_W'(addr));
        write_register(ADDR_TIMEOUT_LIMIT, APB_DATA_W'(limit));
        pending_words.delete();
        last_len = -1;
        if (long_packets) begin
            // One packet longer than the slot counter can count drives it into
            // saturation and runs past the last addressable slot.
            queue_packet(SLOT_COUNT_LIMIT_DEFAULT + 1, 1'b0);
        end else begin
            while (pending_words.size() < budget) begin
                r = $urandom_range(99);
                if (r < 30)
                    n = $urandom_range(3, 1);
                else if (r < 42)
                    n = $urandom_range(40, 1);
                else
                    n = 0;
                repeat (n) push_word(OPCODE_TICK, 8'($urandom_range(255)),
                                     1'($urandom_range(1)));
                if ($urandom_range(99) < 8)
                    repeat ($urandom_range(4, 1))
                        push_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
                if (last_len >= 0 && $urandom_range(99) < 65)
                    data_len = last_len;
                else if ($urandom_range(99) < 75)
                    data_len = $urandom_range(addr + 6, addr + 3);
                else
                    data_len = $urandom_range(addr + 4, 0);
                last_len = data_len;
                queue_packet(data_len, 1'b1);
            end
        end
        // A closing break ends the last packet, so that it can commit.
        push_word(OPCODE_BYTE, 8'h00, 1'b1);
        for (int i = 0; i < pending_words.size(); i++) begin
            if (pause_midway && i == pending_words.size() / 2) begin
                // Hold the input back until the block has nothing left in flight.
                s_axis_tvalid <= 1'b0;
                while (expected_levels.size() != 0)
                    @(posedge i_clk);
                @(negedge i_clk);
            end
            send_word(pending_words[i], 1'b0, DARK);
        end
        phases_run++;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OPCODE_BYTE;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        // Expected state after reset.
        cfg_slot_address  = SLOT_ADDRESS_RESET;
        cfg_timeout_limit = TIMEOUT_LIMIT_RESET;
        rx_slot_count     = '0;
        rx_prev_size      = '0;
        rx_packet_good    = 1'b0;
        cap_red           = '0;
        cap_green         = '0;
        cap_blue          = '0;
        held_red          = '0;
        held_green        = '0;
        held_blue         = '0;
        rx_idle_ticks     = TIMEOUT_LIMIT_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Out of reset the idle count already sits at the limit,
        // so the first words read dark, and a tick cannot push the count past it.
        add_row(ROW_WORD, OPCODE_TICK, 8'hFF, 1'b1, 0, 1'b1, DARK);
        // A byte before any break is counted but can never commit.
        add_row(ROW_WORD, OPCODE_BYTE, 8'hFF, 1'b0, 0, 1'b1, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b1, DARK);
        // First full packet: its size differs from the one before, so it is spoiled.
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'hFF, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h80, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b1, DARK);
        // Same size again: this one commits at the next break.
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h12, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h34, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h56, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b0, DARK);
        // A nonzero start code spoils the packet; the held color stays.
        add_row(ROW_WORD, OPCODE_BYTE, 8'h01, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'hAA, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'hBB, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'hCC, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b0, DARK);
        // A frame error on a nonzero byte spoils the packet without counting it.
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h7F, 1'b1, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h01, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h02, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h03, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b0, DARK);
        // With a zero limit a good packet still commits, but goes dark at once.
        add_row(ROW_SET_LIMIT, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_SET_SLOT, OPCODE_BYTE, 8'h00, 1'b0, 1, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h01, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h02, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h03, 1'b0, 0, 1'b0, DARK);
        add_row(ROW_WORD, OPCODE_BYTE, 8'h00, 1'b1, 0, 1'b1, DARK_COMMIT);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WORD: begin
                    send_word(directed_rows[i].word, directed_rows[i].has_literal,
                              directed_rows[i].literal);
                end
                ROW_SET_SLOT: begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                    write_register(ADDR_SLOT_ADDRESS, APB_DATA_W'(directed_rows[i].value));
                end
                default: begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                    write_register(ADDR_TIMEOUT_LIMIT, APB_DATA_W'(directed_rows[i].value));
                end
            endcase
        end

        // Random phases: slot address and timeout limit at their extremes and in
        // between, under every idling pattern. The long-packet phase puts red on
        // the last addressable slot and drives the slot counter into saturation.
        run_phase(0, 1023, 0, 0, PHASE_WORDS, 1'b0, 1'b1);
        run_phase(511, 1, 9, 9, 0, 1'b1, 1'b0);
        run_phase($urandom_range(20, 0), $urandom_range(12, 2), 87, 0, PHASE_WORDS,
                  1'b0, 1'b0);
        run_phase(3, 480, 0, 87, PHASE_WORDS, 1'b0, 1'b0);
        run_phase($urandom_range(40, 0), $urandom_range(1023, 1), 9, 9, PHASE_WORDS,
                  1'b0, 1'b0);
        run_phase(1, 0, 0, 0, PHASE_WORDS / 2, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d words in %0d random phases plus the directed table, %0d results",
                 words_sent, phases_run, results_seen);
        $display("summary: %0d commits, %0d dark results, %0d register writes, %0d failures",
                 commits_seen, dark_results, reg_writes, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/dmx_rx_pkg.sv
hdl/dmx_rx_regs.sv
hdl/dmx_rx_core.sv
hdl/dmx512_three_slot_receiver_top.sv
tb/sv/dmx512_three_slot_receiver_top_test.sv
